### design/fipd_pkg.sv
// fall impact peak detector: shared types, widths, codes and reset values
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package fipd_pkg;

    // sample and magnitude widths
    localparam int SAMPLE_WIDTH = 14;
    localparam int SUM_W        = 2 * SAMPLE_WIDTH;
    localparam int THRESH_W     = 28;
    localparam int CMP_W        = (SUM_W > THRESH_W) ? SUM_W : THRESH_W;
    localparam int WIN_W        = 10;
    localparam int TMR_W        = 16;
    localparam int ROOT_W       = 14;

    // square root unit
    localparam int ROOT_STEPS   = SAMPLE_WIDTH;
    localparam int REM_W        = SAMPLE_WIDTH + 3;
    localparam int STEP_CNT_W   = $clog2(ROOT_STEPS + 1);

    // stream packing
    localparam int IN_DATA_W    = ((3 * SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 2 + 1 + 1 + ROOT_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

    // configuration port
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 28;

    localparam logic [THRESH_W-1:0] THRESH_RST = THRESH_W'(7000);
    localparam logic [WIN_W-1:0]    WINDOW_RST = WIN_W'(100);
    localparam logic [TMR_W-1:0]    TIMEOUT_RST = TMR_W'(10000);
    localparam logic [TMR_W-1:0]    HALF_RST   = TMR_W'(500);

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_FALL   = 2'd2,
        OP_KEY    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        PH_WAIT   = 2'd0,
        PH_DETECT = 2'd1,
        PH_TRACK  = 2'd2,
        PH_SHOW   = 2'd3
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESH  = 2'd0,
        CFG_WINDOW  = 2'd1,
        CFG_TIMEOUT = 2'd2,
        CFG_HALF    = 2'd3
    } cfg_idx_t;

endpackage

`default_nettype wire

### design/fipd_mag.sv
// fall impact peak detector: squared magnitude of one three-axis sample
// one shared multiplier, one axis per cycle; uses fipd_pkg
`timescale 1ns / 1ps
`default_nettype none

module fipd_mag
    import fipd_pkg::*;
(
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             start,
    input  wire logic signed [SAMPLE_WIDTH-1:0] accel_x,
    input  wire logic signed [SAMPLE_WIDTH-1:0] accel_y,
    input  wire logic signed [SAMPLE_WIDTH-1:0] accel_z,
    output logic                            done,
    output logic [SUM_W-1:0]                sum
);

    logic [SAMPLE_WIDTH-1:0] abs_x_reg, abs_y_reg, abs_z_reg;
    logic [SAMPLE_WIDTH-1:0] abs_x_next, abs_y_next, abs_z_next;
    logic [SUM_W-1:0]        prod_reg, prod_next;
    logic [SUM_W-1:0]        acc_reg, acc_next;
    logic [1:0]              step_reg, step_next;
    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [SAMPLE_WIDTH-1:0] mul_a;

    function automatic logic [SAMPLE_WIDTH-1:0] abs_of(input logic [SAMPLE_WIDTH-1:0] raw);
        if (raw[SAMPLE_WIDTH-1])
        begin
            return (~raw) + SAMPLE_WIDTH'(1);
        end
        return raw;
    endfunction

    // operand select for the shared multiplier
    always_comb
    begin
        case (step_reg)
            2'd0:    mul_a = abs_x_reg;
            2'd1:    mul_a = abs_y_reg;
            2'd2:    mul_a = abs_z_reg;
            default: mul_a = '0;
        endcase
    end

    always_comb
    begin
        abs_x_next = abs_x_reg;
        abs_y_next = abs_y_reg;
        abs_z_next = abs_z_reg;
        prod_next  = prod_reg;
        acc_next   = acc_reg;
        step_next  = step_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            abs_x_next = abs_of(accel_x);
            abs_y_next = abs_of(accel_y);
            abs_z_next = abs_of(accel_z);
            acc_next   = '0;
            step_next  = 2'd0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            prod_next = SUM_W'(mul_a) * SUM_W'(mul_a);
            if (step_reg != 2'd0)
            begin
                acc_next = acc_reg + prod_reg;
            end
            step_next = step_reg + 2'd1;
            if (step_reg == 2'd3)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 2'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        abs_x_reg <= abs_x_next;
        abs_y_reg <= abs_y_next;
        abs_z_reg <= abs_z_next;
        prod_reg  <= prod_next;
        acc_reg   <= acc_next;
    end

    assign done = done_reg;
    assign sum  = acc_reg;

endmodule

`default_nettype wire

### design/fipd_sqrt.sv
// fall impact peak detector: floor square root, two radicand bits per cycle
// shared compare-subtract unit under a step counter; uses fipd_pkg
`timescale 1ns / 1ps
`default_nettype none

module fipd_sqrt
    import fipd_pkg::*;
(
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     start,
    input  wire  [SUM_W-1:0]        value,
    output logic                    done,
    output logic [SAMPLE_WIDTH-1:0] root
);

    logic [SUM_W-1:0]        val_reg, val_next;
    logic [REM_W-1:0]        rem_reg, rem_next;
    logic [SAMPLE_WIDTH-1:0] root_reg, root_next;
    logic [STEP_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [REM_W-1:0]        work;
    logic [REM_W-1:0]        trial;

    // bring down the next two radicand bits and try root*4+1
    assign work  = {rem_reg[REM_W-3:0], val_reg[SUM_W-1 -: 2]};
    assign trial = {1'b0, root_reg, 2'b01};

    always_comb
    begin
        val_next  = val_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            val_next  = value;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = STEP_CNT_W'(ROOT_STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            val_next = val_reg << 2;
            if (work >= trial)
            begin
                rem_next  = work - trial;
                root_next = {root_reg[SAMPLE_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next  = work;
                root_next = {root_reg[SAMPLE_WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - STEP_CNT_W'(1);
            if (cnt_reg == STEP_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

### design/fall_impact_peak_detector.sv
// fall impact peak detector: top level with phase sequencer and timers
// instantiates fipd_mag and fipd_sqrt; uses fipd_pkg
`timescale 1ns / 1ps
`default_nettype none

// Each input item carries an op in s_tuser (tick of 1 ms, acceleration sample,
// free-fall event or key press) and the three signed axis samples in s_tdata.
// Every item gives exactly one result item: the phase, the warning led level and
// the sensor mode as they stand after the item, plus peak_valid in m_tuser and
// the floor square root of the peak on the tick that closes a measurement.
// The block takes one item at a time and drops s_tready while it works on it.
// Ticks, free-fall events and key presses pass the emit state on their way to
// the result register. A sample first goes through the magnitude unit, where
// the three squares go one per cycle through a single shared multiplier and are
// summed into one accumulator. The tick that ends peak tracking waits on the
// square root unit, which resolves one root bit per cycle over 14 steps.
// A result not yet taken does not stop the next item from being accepted;
// the block only waits to load the result register while it is still full.
// Configuration writes are taken in any cycle (cfg_ready is always high) and
// are meant to be issued only while the block is idle.
module fall_impact_peak_detector
    import fipd_pkg::*;
(
    input  wire                    clk,
    input  wire                    rst_n,
    // input stream
    input  wire                    s_tvalid,
    output logic                   s_tready,
    input  wire  [IN_DATA_W-1:0]   s_tdata,    // accel_x, accel_y, accel_z, zero pad
    input  wire  [1:0]             s_tuser,    // op
    // result stream
    output logic                   m_tvalid,
    input  wire                    m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata,    // phase, warning_led, sample_mode,
                                               // peak_root, zero pad
    output logic                   m_tuser,    // peak_valid
    // configuration write channel
    input  wire                    cfg_valid,
    output logic                   cfg_ready,
    input  wire  [CFG_IDX_W-1:0]   cfg_index,
    input  wire  [CFG_DATA_W-1:0]  cfg_data
);

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MAG  = 4'b0010,
        ST_ROOT = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    phase_t                 phase_reg, phase_next;
    logic [SUM_W-1:0]       peak_reg, peak_next;
    logic [WIN_W-1:0]       win_cnt_reg, win_cnt_next;
    logic [TMR_W-1:0]       tmo_cnt_reg, tmo_cnt_next;
    logic [TMR_W-1:0]       blink_cnt_reg, blink_cnt_next;
    logic                   led_reg, led_next;
    logic                   blinking_reg, blinking_next;
    logic                   pend_valid_reg, pend_valid_next;

    // configuration registers
    logic [THRESH_W-1:0]    thresh_reg, thresh_next;
    logic [WIN_W-1:0]       win_ticks_reg, win_ticks_next;
    logic [TMR_W-1:0]       tmo_ticks_reg, tmo_ticks_next;
    logic [TMR_W-1:0]       half_reg, half_next;

    // result register
    logic                   out_full_reg, out_full_next;
    phase_t                 out_phase_reg, out_phase_next;
    logic                   out_led_reg, out_led_next;
    logic                   out_mode_reg, out_mode_next;
    logic                   out_valid_reg, out_valid_next;
    logic [ROOT_W-1:0]      out_root_reg, out_root_next;

    logic                   accept;
    op_t                    op;
    logic                   mag_start, mag_done;
    logic [SUM_W-1:0]       mag_sum;
    logic                   sqrt_start, sqrt_done;
    logic [SAMPLE_WIDTH-1:0] sqrt_root;
    logic [TMR_W-1:0]       blink_dec;
    logic [WIN_W-1:0]       win_dec;
    logic [TMR_W-1:0]       tmo_dec;
    logic                   out_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign op        = op_t'(s_tuser);
    assign cfg_ready = 1'b1;
    // result slot can take a new item this cycle
    assign out_free  = !out_full_reg || m_tready;

    // timers stop at zero
    assign blink_dec = (blink_cnt_reg != '0) ? blink_cnt_reg - TMR_W'(1) : blink_cnt_reg;
    assign win_dec   = (win_cnt_reg != '0) ? win_cnt_reg - WIN_W'(1) : win_cnt_reg;
    assign tmo_dec   = (tmo_cnt_reg != '0) ? tmo_cnt_reg - TMR_W'(1) : tmo_cnt_reg;

    assign mag_start  = accept && (op == OP_SAMPLE);
    // a tick that empties the window closes the measurement
    assign sqrt_start = accept && (op == OP_TICK) && (phase_reg == PH_TRACK)
                        && (win_dec == '0);

    fipd_mag u_mag (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mag_start),
        .accel_x (s_tdata[SAMPLE_WIDTH-1:0]),
        .accel_y (s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
        .accel_z (s_tdata[3*SAMPLE_WIDTH-1:2*SAMPLE_WIDTH]),
        .done    (mag_done),
        .sum     (mag_sum)
    );

    // peak is sampled into the root unit at the same edge that clears it
    fipd_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .value (peak_reg),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        peak_next       = peak_reg;
        win_cnt_next    = win_cnt_reg;
        tmo_cnt_next    = tmo_cnt_reg;
        blink_cnt_next  = blink_cnt_reg;
        led_next        = led_reg;
        blinking_next   = blinking_reg;
        pend_valid_next = pend_valid_reg;
        thresh_next     = thresh_reg;
        win_ticks_next  = win_ticks_reg;
        tmo_ticks_next  = tmo_ticks_reg;
        half_next       = half_reg;
        out_full_next   = out_full_reg && !m_tready;
        out_phase_next  = out_phase_reg;
        out_led_next    = out_led_reg;
        out_mode_next   = out_mode_reg;
        out_valid_next  = out_valid_reg;
        out_root_next   = out_root_reg;

        // register writes
        if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_THRESH:  thresh_next    = cfg_data[THRESH_W-1:0];
                CFG_WINDOW:  win_ticks_next = cfg_data[WIN_W-1:0];
                CFG_TIMEOUT: tmo_ticks_next = cfg_data[TMR_W-1:0];
                CFG_HALF:    half_next      = cfg_data[TMR_W-1:0];
                default:     ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    pend_valid_next = 1'b0;
                    state_next      = ST_EMIT;
                    case (op)
                        OP_TICK:
                        begin
                            blink_cnt_next = blink_dec;
                            win_cnt_next   = win_dec;
                            tmo_cnt_next   = tmo_dec;
                            // led toggles when the half period runs out
                            if (blinking_reg && (blink_dec == '0))
                            begin
                                led_next       = !led_reg;
                                blink_cnt_next = half_reg;
                            end
                            if (sqrt_start)
                            begin
                                pend_valid_next = 1'b1;
                                peak_next       = '0;
                                tmo_cnt_next    = tmo_ticks_reg;
                                phase_next      = PH_SHOW;
                                state_next      = ST_ROOT;
                            end
                            else if ((phase_reg == PH_SHOW) && (tmo_dec == '0))
                            begin
                                phase_next    = PH_WAIT;
                                blinking_next = 1'b0;
                                led_next      = 1'b0;
                            end
                        end
                        OP_SAMPLE:
                        begin
                            state_next = ST_MAG;
                        end
                        OP_FALL:
                        begin
                            if (phase_reg == PH_WAIT)
                            begin
                                phase_next     = PH_DETECT;
                                blinking_next  = 1'b1;
                                led_next       = 1'b1;
                                blink_cnt_next = half_reg;
                            end
                        end
                        OP_KEY:
                        begin
                            if (phase_reg == PH_SHOW)
                            begin
                                phase_next    = PH_WAIT;
                                blinking_next = 1'b0;
                                led_next      = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_MAG:
            begin
                if (mag_done)
                begin
                    state_next = ST_EMIT;
                    if (phase_reg == PH_DETECT)
                    begin
                        // impact starts peak tracking
                        if (CMP_W'(mag_sum) >= CMP_W'(thresh_reg))
                        begin
                            peak_next    = mag_sum;
                            win_cnt_next = win_ticks_reg;
                            phase_next   = PH_TRACK;
                        end
                    end
                    else if (phase_reg == PH_TRACK)
                    begin
                        // every new peak restarts the window
                        if (mag_sum > peak_reg)
                        begin
                            peak_next    = mag_sum;
                            win_cnt_next = win_ticks_reg;
                        end
                    end
                end
            end
            ST_ROOT:
            begin
                if (sqrt_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_full_next  = 1'b1;
                    out_phase_next = phase_reg;
                    out_led_next   = led_reg;
                    out_mode_next  = (phase_reg != PH_WAIT);
                    out_valid_next = pend_valid_reg;
                    out_root_next  = pend_valid_reg ? ROOT_W'(sqrt_root) : '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            phase_reg      <= PH_WAIT;
            peak_reg       <= '0;
            win_cnt_reg    <= '0;
            tmo_cnt_reg    <= '0;
            blink_cnt_reg  <= '0;
            led_reg        <= 1'b0;
            blinking_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            thresh_reg     <= THRESH_RST;
            win_ticks_reg  <= WINDOW_RST;
            tmo_ticks_reg  <= TIMEOUT_RST;
            half_reg       <= HALF_RST;
            out_full_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            peak_reg       <= peak_next;
            win_cnt_reg    <= win_cnt_next;
            tmo_cnt_reg    <= tmo_cnt_next;
            blink_cnt_reg  <= blink_cnt_next;
            led_reg        <= led_next;
            blinking_reg   <= blinking_next;
            pend_valid_reg <= pend_valid_next;
            thresh_reg     <= thresh_next;
            win_ticks_reg  <= win_ticks_next;
            tmo_ticks_reg  <= tmo_ticks_next;
            half_reg       <= half_next;
            out_full_reg   <= out_full_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        out_phase_reg <= out_phase_next;
        out_led_reg   <= out_led_next;
        out_mode_reg  <= out_mode_next;
        out_valid_reg <= out_valid_next;
        out_root_reg  <= out_root_next;
    end

    assign m_tvalid = out_full_reg;
    assign m_tdata  = {OUT_PAD_W'(0), out_root_reg, out_mode_reg, out_led_reg, out_phase_reg};
    assign m_tuser  = out_valid_reg;

endmodule

`default_nettype wire

### test/fall_impact_peak_detector_tb.sv
// self-checking bench for the fall impact peak detector: directed table, then random falls
// depends on fipd_pkg and fall_impact_peak_detector from the design folder
`timescale 1ns / 1ps

module fall_impact_peak_detector_tb;
    import fipd_pkg::*;

    // one result item as the bench sees it, lowest field first in m_tdata
    typedef struct packed {
        phase_t            ph;
        logic              led;
        logic              mode;
        logic              pv;
        logic [ROOT_W-1:0] root;
    } peak_report_t;

    // timing register set written in one go while the block is quiet
    typedef struct {
        logic [THRESH_W-1:0] thr;
        logic [WIN_W-1:0]    win;
        logic [TMR_W-1:0]    tmo;
        logic [TMR_W-1:0]    half;
    } timing_set_t;

    // directed row: optional register set to load first, the item, and a
    // hand-written result where the outcome is obvious
    typedef struct {
        int                        cfg_sel;
        op_t                       op;
        logic signed [SAMPLE_WIDTH-1:0] x;
        logic signed [SAMPLE_WIDTH-1:0] y;
        logic signed [SAMPLE_WIDTH-1:0] z;
        logic                      pin;
        peak_report_t              want;
    } probe_row_t;

    localparam logic signed [SAMPLE_WIDTH-1:0] FS_POS = 14'sd8191;
    localparam logic signed [SAMPLE_WIDTH-1:0] FS_NEG = -14'sd8192;
    localparam logic [THRESH_W-1:0] THRESH_TOP = 28'd201326592;

    localparam peak_report_t REP_IDLE   = '{PH_WAIT, 1'b0, 1'b0, 1'b0, 14'd0};
    localparam peak_report_t REP_DETECT = '{PH_DETECT, 1'b1, 1'b1, 1'b0, 14'd0};
    localparam peak_report_t REP_TRACK  = '{PH_TRACK, 1'b1, 1'b1, 1'b0, 14'd0};

    // clock and reset
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #4 clk = ~clk;

    // block ports, the bench-driven ones at known levels from time zero
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [1:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    cfg_idx_t              cfg_index = CFG_THRESH;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    fall_impact_peak_detector dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predicted detector state and the registers as last written
    logic [THRESH_W-1:0] thr_r = THRESH_RST;
    logic [WIN_W-1:0]    win_r = WINDOW_RST;
    logic [TMR_W-1:0]    tmo_r = TIMEOUT_RST;
    logic [TMR_W-1:0]    half_r = HALF_RST;

    phase_t              ph_q = PH_WAIT;
    logic [THRESH_W-1:0] peak_q = '0;
    logic [WIN_W-1:0]    win_q = '0;
    logic [TMR_W-1:0]    tmo_q = '0;
    logic [TMR_W-1:0]    blink_q = '0;
    logic                led_q = 1'b0;
    logic                blinking_q = 1'b0;

    // results still owed by the block, oldest first
    peak_report_t reports_due [$];

    int err_count = 0;
    int items_sent = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;

    // register sets for the directed rows: extreme thresholds, short and long timers
    timing_set_t probe_sets [2] = '{
        '{THRESH_TOP, 10'd1, 16'd1, 16'd1},
        '{28'd0, 10'd2, 16'hFFFF, 16'hFFFF}
    };

    probe_row_t probes [21] = '{
        // straight after reset: nothing but a fall event leaves waiting
        '{-1, OP_TICK,   14'sd0, 14'sd0, 14'sd0, 1'b1, REP_IDLE},
        '{-1, OP_KEY,    FS_POS, FS_NEG, 14'sd0, 1'b1, REP_IDLE},
        '{-1, OP_SAMPLE, FS_POS, FS_NEG, -14'sd1, 1'b1, REP_IDLE},
        // top threshold, shortest window, timeout and blink
        '{0,  OP_FALL,   14'sd0, 14'sd0, 14'sd0, 1'b1, REP_DETECT},
        '{-1, OP_FALL,   -14'sd1, -14'sd1, -14'sd1, 1'b1, REP_DETECT},
        '{-1, OP_KEY,    14'sd0, 14'sd0, 14'sd0, 1'b1, REP_DETECT},
        // just short of the top threshold
        '{-1, OP_SAMPLE, FS_POS, FS_POS, FS_POS, 1'b1, REP_DETECT},
        '{-1, OP_TICK,   14'sd0, 14'sd0, 14'sd0, 1'b0, REP_IDLE},
        // largest magnitude reaches it exactly
        '{-1, OP_SAMPLE, FS_NEG, FS_NEG, FS_NEG, 1'b0, REP_IDLE},
        '{-1, OP_SAMPLE, FS_POS, -14'sd8191, 14'sd100, 1'b0, REP_IDLE},
        // window runs out: largest root
        '{-1, OP_TICK,   14'sd0, 14'sd0, 14'sd0, 1'b0, REP_IDLE},
        '{-1, OP_SAMPLE, FS_NEG, FS_NEG, FS_NEG, 1'b0, REP_IDLE},
        '{-1, OP_FALL,   14'sd0, 14'sd0, 14'sd0, 1'b0, REP_IDLE},
        // display timeout returns to waiting
        '{-1, OP_TICK,   14'sd0, 14'sd0, 14'sd0, 1'b1, REP_IDLE},
        // zero threshold, longest timeout and blink
        '{1,  OP_FALL,   FS_POS, FS_POS, FS_POS, 1'b1, REP_DETECT},
        '{-1, OP_SAMPLE, 14'sd0, 14'sd0, 14'sd0, 1'b1, REP_TRACK},
        '{-1, OP_SAMPLE, -14'sd1, 14'sd0, 14'sd0, 1'b0, REP_IDLE},
        '{-1, OP_KEY,    14'sd0, 14'sd0, 14'sd0, 1'b0, REP_IDLE},
        '{-1, OP_TICK,   14'sd0, 14'sd0, 14'sd0, 1'b0, REP_IDLE},
        '{-1, OP_TICK,   14'sd0, 14'sd0, 14'sd0, 1'b0, REP_IDLE},
        // key press ends the display
        '{-1, OP_KEY,    FS_NEG, FS_POS, FS_NEG, 1'b1, REP_IDLE}
    };

    // floor square root, one bit at a time from the top
    function automatic logic [ROOT_W-1:0] floor_root(logic [THRESH_W-1:0] v);
        logic [ROOT_W-1:0] r;
        logic [ROOT_W-1:0] trial;
        r = '0;
        for (int b = ROOT_W - 1; b >= 0; b--)
        begin
            trial = r | (ROOT_W'(1) << b);
            if (32'(trial) * 32'(trial) <= 32'(v))
                r = trial;
        end
        return r;
    endfunction

    // back to waiting: led off, blinking stops
    function automatic void end_fall();
        ph_q = PH_WAIT;
        blinking_q = 1'b0;
        led_q = 1'b0;
    endfunction

    // moves the predicted state on by one item and gives the result it causes
    function automatic peak_report_t advance_detector(op_t op,
                                                      logic signed [SAMPLE_WIDTH-1:0] x,
                                                      logic signed [SAMPLE_WIDTH-1:0] y,
                                                      logic signed [SAMPLE_WIDTH-1:0] z);
        peak_report_t rep;
        logic [THRESH_W-1:0] mag_sq;
        rep = REP_IDLE;
        mag_sq = THRESH_W'(int'(x) * int'(x) + int'(y) * int'(y) + int'(z) * int'(z));
        case (op)
            OP_TICK:
            begin
                // counters stop at zero
                if (blink_q != 0) blink_q = blink_q - 1'b1;
                if (win_q != 0) win_q = win_q - 1'b1;
                if (tmo_q != 0) tmo_q = tmo_q - 1'b1;
                if (blinking_q && blink_q == 0)
                begin
                    led_q = ~led_q;
                    blink_q = half_r;
                end
                if (ph_q == PH_TRACK && win_q == 0)
                begin
                    rep.pv = 1'b1;
                    rep.root = floor_root(peak_q);
                    peak_q = '0;
                    tmo_q = tmo_r;
                    ph_q = PH_SHOW;
                end
                else if (ph_q == PH_SHOW && tmo_q == 0)
                    end_fall();
            end
            OP_SAMPLE:
            begin
                if (ph_q == PH_DETECT && mag_sq >= thr_r)
                begin
                    peak_q = mag_sq;
                    win_q = win_r;
                    ph_q = PH_TRACK;
                end
                else if (ph_q == PH_TRACK && mag_sq > peak_q)
                begin
                    peak_q = mag_sq;
                    win_q = win_r;
                end
            end
            OP_FALL:
            begin
                if (ph_q == PH_WAIT)
                begin
                    ph_q = PH_DETECT;
                    blinking_q = 1'b1;
                    led_q = 1'b1;
                    blink_q = half_r;
                end
            end
            default:
            begin
                if (ph_q == PH_SHOW)
                    end_fall();
            end
        endcase
        rep.ph = ph_q;
        rep.led = led_q;
        rep.mode = (ph_q != PH_WAIT);
        return rep;
    endfunction

    // one axis value: full range, near zero, full scale or mid range
    function automatic logic signed [SAMPLE_WIDTH-1:0] pick_axis();
        case ($urandom_range(3))
            0: return SAMPLE_WIDTH'($urandom);
            1: return SAMPLE_WIDTH'(int'($urandom_range(128)) - 64);
            2: return $urandom_range(1) ? FS_NEG : FS_POS;
            default: return SAMPLE_WIDTH'(int'($urandom_range(8000)) - 4000);
        endcase
    endfunction

    // offers one item, waits for the handshake and books its expected result;
    // tvalid is only lowered when a gap is taken, never in the acceptance step
    // of a back-to-back item
    task automatic push_item(op_t op,
                             logic signed [SAMPLE_WIDTH-1:0] x,
                             logic signed [SAMPLE_WIDTH-1:0] y,
                             logic signed [SAMPLE_WIDTH-1:0] z,
                             logic pin = 1'b0,
                             peak_report_t want = REP_IDLE);
        peak_report_t due;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= IN_DATA_W'({z, y, x});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        // the predictor always advances; a typed row overrides its answer
        due = advance_detector(op, x, y, z);
        reports_due.push_back(pin ? want : due);
        items_sent++;
    endtask

    task automatic send_op(op_t op);
        push_item(op, pick_axis(), pick_axis(), pick_axis());
    endtask

    task automatic send_noise();
        send_op(op_t'($urandom_range(3)));
    endtask

    // drop tvalid, let every owed result come back, then allow for the
    // longest internal latency before touching the registers
    task automatic settle();
        s_tvalid <= 1'b0;
        while (reports_due.size() != 0)
            @(posedge clk);
        repeat (24) @(posedge clk);
    endtask

    // cfg_valid stays high across the burst and is dropped by the caller
    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_THRESH:  thr_r = value[THRESH_W-1:0];
            CFG_WINDOW:  win_r = value[WIN_W-1:0];
            CFG_TIMEOUT: tmo_r = value[TMR_W-1:0];
            default:     half_r = value[TMR_W-1:0];
        endcase
    endtask

    task automatic load_settings(timing_set_t ts);
        write_reg(CFG_THRESH, CFG_DATA_W'(ts.thr));
        write_reg(CFG_WINDOW, CFG_DATA_W'(ts.win));
        write_reg(CFG_TIMEOUT, CFG_DATA_W'(ts.tmo));
        write_reg(CFG_HALF, CFG_DATA_W'(ts.half));
        cfg_valid <= 1'b0;
    endtask

    // one fall as the sensor would see it: free-fall event, a burst of
    // samples, ticks until the window closes, then key press or timeout;
    // the predicted phase steers it so that most falls reach the display
    task automatic run_fall();
        int guard;
        if ($urandom_range(9) == 0)
            send_noise();
        send_op(OP_FALL);
        repeat ($urandom_range(1, 6))
        begin
            if ($urandom_range(3) == 0)
                send_op(OP_TICK);
            send_op(OP_SAMPLE);
        end
        // a full-scale hit clears even the top threshold, and always comes
        // when nothing smaller could
        if (ph_q == PH_DETECT && ($urandom_range(3) != 0 || thr_r == THRESH_TOP))
            push_item(OP_SAMPLE, FS_NEG, FS_NEG, FS_NEG);
        guard = 0;
        while (ph_q == PH_TRACK && guard < 4 * int'(win_r) + 40)
        begin
            if ($urandom_range(9) == 0)
                send_op(OP_SAMPLE);
            else if ($urandom_range(19) == 0)
                send_noise();
            else
                send_op(OP_TICK);
            guard++;
        end
        if (ph_q == PH_SHOW)
        begin
            repeat ($urandom_range(3))
                send_op(OP_TICK);
            if (tmo_r > 64 || $urandom_range(1) == 0)
                send_op(OP_KEY);
            else
                while (ph_q == PH_SHOW)
                    send_op(OP_TICK);
        end
    endtask

    // receiver: random stalls, or a long hold-off when one is requested
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                hold_cycles--;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result checker: every accepted result against the oldest expectation
    always @(posedge clk)
    begin
        peak_report_t got;
        peak_report_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.ph   = phase_t'(m_tdata[1:0]);
            got.led  = m_tdata[2];
            got.mode = m_tdata[3];
            got.root = m_tdata[4 +: ROOT_W];
            got.pv   = m_tuser;
            if (reports_due.size() == 0)
            begin
                $display("%0t: result item with nothing expected: phase %0d led %0b",
                         $time, got.ph, got.led);
                err_count++;
            end
            else
            begin
                want = reports_due.pop_front();
                if (got.ph !== want.ph || got.led !== want.led || got.mode !== want.mode ||
                    got.pv !== want.pv || got.root !== want.root)
                begin
                    $display("%0t: expected phase %0d led %0b mode %0b valid %0b root %0d",
                             $time, want.ph, want.led, want.mode, want.pv, want.root);
                    $display("%0t:   actual phase %0d led %0b mode %0b valid %0b root %0d",
                             $time, got.ph, got.led, got.mode, got.pv, got.root);
                    err_count++;
                end
            end
        end
    end

    // stimulus: directed table, then eight random phases, each with its register
    // set and one of four idling patterns
    initial
    begin
        timing_set_t phase_set;
        int budget;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (probes[i])
        begin
            if (probes[i].cfg_sel >= 0)
            begin
                settle();
                load_settings(probe_sets[probes[i].cfg_sel]);
            end
            push_item(probes[i].op, probes[i].x, probes[i].y, probes[i].z,
                      probes[i].pin, probes[i].want);
        end

        for (int k = 0; k < 8; k++)
        begin
            settle();
            case (k)
                // every timer at its longest, threshold at its top
                2: phase_set = '{THRESH_TOP, 10'd1023, 16'hFFFF, 16'hFFFF};
                // zero timers expire on the very next tick
                5: phase_set = '{28'd0, 10'd0, 16'd0, 16'd0};
                default:
                begin
                    case ($urandom_range(3))
                        0: phase_set.thr = THRESH_W'($urandom_range(2000));
                        1: phase_set.thr = THRESH_W'($urandom_range(20000, 2000000));
                        2: phase_set.thr = THRESH_W'($urandom_range(THRESH_TOP));
                        default: phase_set.thr = THRESH_TOP;
                    endcase
                    phase_set.win  = WIN_W'($urandom_range(1, 8));
                    phase_set.tmo  = TMR_W'($urandom_range(1, 40));
                    phase_set.half = TMR_W'($urandom_range(1, 12));
                end
            endcase
            load_settings(phase_set);

            case (k % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 81;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 81;
                end
                default:
                begin
                    send_idle_pct = 21;
                    recv_stall_pct = 21;
                end
            endcase
            // long hold-off with the sender flat out, so the block backs up
            if (k == 0)
                hold_cycles = 400;

            // the slow extreme phase gets a single fall of over a thousand items
            budget = items_sent + ((k == 2) ? 1 : 110);
            while (items_sent < budget)
                run_fall();
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        settle();
        if (err_count == 0)
            $display("fall_impact_peak_detector_tb: clean");
        else
            $display("fall_impact_peak_detector_tb: errors");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #40_000_000;
        $display("fall_impact_peak_detector_tb: errors");
        $finish;
    end

endmodule
